### src/sart_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the sonar average and
// report trigger block. No dependencies.
package sart_pkg;

  // Geometry
  localparam int CHANNELS      = 6;
  localparam int WINDOW_LENGTH = 8;
  localparam int RAW_W         = 16;
  localparam int SAMPLE_W      = 8;
  localparam int SAMPLE_MAX    = 255;
  localparam int PREFILL       = 100;
  localparam int TIME_W        = 32;
  localparam int LIMIT_W       = 8;
  localparam int INTERVAL_W    = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 3;

  localparam int SUM_W = $clog2(SAMPLE_MAX * WINDOW_LENGTH + 1);
  localparam int POS_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

  // Fixed change thresholds, scaled to window sums
  localparam logic [SUM_W-1:0] PREFILL_SUM  = SUM_W'(PREFILL * WINDOW_LENGTH);
  localparam logic [SUM_W-1:0] HIGH_DELTA   = SUM_W'(2 * WINDOW_LENGTH);
  localparam logic [SUM_W-1:0] MEDIUM_DELTA = SUM_W'(4 * WINDOW_LENGTH);
  localparam logic [SAMPLE_W-1:0] PREFILL_SAMPLE = SAMPLE_W'(PREFILL);
  localparam logic [SAMPLE_W-1:0] SAMPLE_SAT     = SAMPLE_W'(SAMPLE_MAX);

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_NEAR       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_NEAR     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_JUMP       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_JUMP     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_INTERVAL   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_INTERVAL = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_INTERVAL    = 3'd6;

  // Register reset values (limits held pre-scaled by the window length)
  localparam logic [SUM_W-1:0] RST_HIGH_NEAR   = SUM_W'(30 * WINDOW_LENGTH);
  localparam logic [SUM_W-1:0] RST_MEDIUM_NEAR = SUM_W'(50 * WINDOW_LENGTH);
  localparam logic [SUM_W-1:0] RST_HIGH_JUMP   = SUM_W'(20 * WINDOW_LENGTH);
  localparam logic [SUM_W-1:0] RST_MEDIUM_JUMP = SUM_W'(10 * WINDOW_LENGTH);
  localparam logic [INTERVAL_W-1:0] RST_HIGH_INTERVAL   = 16'd10;
  localparam logic [INTERVAL_W-1:0] RST_MEDIUM_INTERVAL = 16'd40;
  localparam logic [INTERVAL_W-1:0] RST_MAX_INTERVAL    = 16'd200;

  // Urgency codes
  localparam logic [1:0] URG_NONE   = 2'd0;
  localparam logic [1:0] URG_MEDIUM = 2'd1;
  localparam logic [1:0] URG_HIGH   = 2'd2;

  // Reciprocal for sum / WINDOW_LENGTH, exact for any SUM_W-bit sum
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
  localparam int DIV_RECIP = ((1 << DIV_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam int RECIP_W   = SUM_W + 2;
  localparam int PROD_W    = SUM_W + RECIP_W;

  typedef struct packed {
    logic [SUM_W-1:0] high_near;
    logic [SUM_W-1:0] medium_near;
    logic [SUM_W-1:0] high_jump;
    logic [SUM_W-1:0] medium_jump;
  } sart_limits_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] high;
    logic [INTERVAL_W-1:0] mid;
    logic [INTERVAL_W-1:0] max;
  } sart_intervals_t;

  typedef struct packed {
    logic high;
    logic mid;
  } sart_flags_t;

  typedef struct packed {
    logic                               report_valid;
    logic [1:0]                         urgency;
    logic [CHANNELS-1:0][SAMPLE_W-1:0]  avg;
  } sart_result_t;

  // Limit register scaled to window-sum units
  function automatic logic [SUM_W-1:0] scale_limit(input logic [LIMIT_W-1:0] v);
    return SUM_W'(32'(v) * WINDOW_LENGTH);
  endfunction

  // Window average by reciprocal multiplication
  function automatic logic [SAMPLE_W-1:0] avg_of(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(DIV_RECIP);
    return SAMPLE_W'(prod >> DIV_SHIFT);
  endfunction

endpackage

### src/sart_lane.sv
`timescale 1ns / 1ps
// One sensor channel: saturation, sample window store, running sum and
// urgency grading against the last reported sum. Depends on sart_pkg.
module sart_lane import sart_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [RAW_W-1:0]      distance,
  input  logic [POS_W-1:0]      pos,
  input  logic [POS_W-1:0]      pos_next,
  input  logic                  filled,
  input  sart_limits_t          limits,
  input  logic                  fire,
  output logic [SUM_W-1:0]      sum_new,
  output sart_flags_t           flags
);

  logic [SAMPLE_W-1:0] samples [WINDOW_LENGTH];
  logic [SAMPLE_W-1:0] old_q;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] old_sample;
  logic [POS_W-1:0]    rd_addr;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    reported;
  logic [SUM_W-1:0]    diff;

  // Saturate the raw reading
  assign sample = (distance > RAW_W'(SAMPLE_MAX)) ? SAMPLE_SAT : distance[SAMPLE_W-1:0];

  // Window store; the oldest sample for the next word is read ahead into a register
  assign rd_addr = accept ? pos_next : pos;

  always_ff @(posedge clk) begin
    if (accept) begin
      samples[pos] <= sample;
    end
    if (accept && (pos_next == pos)) begin
      old_q <= sample;
    end else begin
      old_q <= samples[rd_addr];
    end
  end

  // Entries not yet written since reset read as the prefill value
  assign old_sample = filled ? old_q : PREFILL_SAMPLE;

  // Running sum
  assign sum_new = SUM_W'({1'b0, sum} + (SUM_W + 1)'(sample) - (SUM_W + 1)'(old_sample));

  // Distance from last reported sum and grading
  assign diff = (reported > sum_new) ? (reported - sum_new) : (sum_new - reported);

  always_comb begin
    flags.high = ((sum_new < limits.high_near) && (diff > HIGH_DELTA)) ||
                 (diff > limits.high_jump);
    flags.mid  = !flags.high &&
                 (((sum_new < limits.medium_near) && (diff > MEDIUM_DELTA)) ||
                  (diff > limits.medium_jump));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= PREFILL_SUM;
      reported <= '0;
    end else if (accept) begin
      sum <= sum_new;
      if (fire) begin
        reported <= sum_new;
      end
    end
  end

endmodule

### src/sart_merge.sv
`timescale 1ns / 1ps
// Merges the lane flags into one urgency, decides whether to report and
// forms the result word. Depends on sart_pkg.
module sart_merge import sart_pkg::*; (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [CHANNELS-1:0][SUM_W-1:0]    sums,
  input  sart_flags_t [CHANNELS-1:0]        lane_flags,
  input  logic [TIME_W-1:0]                 now_ms,
  input  sart_intervals_t                   intervals,
  output logic                              fire,
  output sart_result_t                      result
);

  logic [TIME_W-1:0] last_report_ms;
  logic [TIME_W-1:0] elapsed;
  logic [CHANNELS-1:0] high_vec;
  logic [CHANNELS-1:0] medium_vec;
  logic              any_high;
  logic              any_medium;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      high_vec[c]   = lane_flags[c].high;
      medium_vec[c] = lane_flags[c].mid;
    end
  end

  assign any_high   = |high_vec;
  assign any_medium = |medium_vec;

  // Report decision, elapsed time wraps
  assign elapsed = now_ms - last_report_ms;
  assign fire = (any_high   && (elapsed > TIME_W'(intervals.high))) ||
                (any_medium && (elapsed > TIME_W'(intervals.mid)))  ||
                (elapsed > TIME_W'(intervals.max));

  // Result word
  always_comb begin
    result.report_valid = fire;
    if (any_high) begin
      result.urgency = URG_HIGH;
    end else if (any_medium) begin
      result.urgency = URG_MEDIUM;
    end else begin
      result.urgency = URG_NONE;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      result.avg[c] = fire ? avg_of(sums[c]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_report_ms <= '0;
    end else if (accept && fire) begin
      last_report_ms <= now_ms;
    end
  end

endmodule

### src/sart_outbuf.sv
`timescale 1ns / 1ps
// Two-entry output buffer: output register plus skid word, so the input
// side keeps accepting while one result waits. Depends on sart_pkg.
module sart_outbuf import sart_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          push_ready,
  input  sart_result_t  push_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sart_result_t  out_data
);

  logic         skid_valid;
  sart_result_t skid_data;

  // No words taken while in reset
  assign push_ready = !skid_valid && !rst;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Data
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

### src/sonar_average_report_trigger_unit.sv
`timescale 1ns / 1ps
// Top level of the sonar average and report trigger block.
// Depends on sart_pkg, sart_lane, sart_merge and sart_outbuf.
//
// Takes one word per clock: six distance readings and a millisecond time.
// Six lanes update their moving-sum windows side by side and grade urgency,
// then a merge stage decides on a report; the result word of each accepted
// input is registered at the output. A two-entry output buffer lets in_ready
// stay high while one result waits, so one word per cycle is sustained as
// long as the output side drains at that rate. Window entries start at 100
// without a clearing pass: until the window has wrapped once the prefill
// value stands in for the stored sample. Configuration writes take effect
// on the next word and should only be made while the block is idle.
module sonar_average_report_trigger_unit import sart_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // input word
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [RAW_W-1:0]       distance_front_left,
  input  logic [RAW_W-1:0]       distance_front_right,
  input  logic [RAW_W-1:0]       distance_back_left,
  input  logic [RAW_W-1:0]       distance_back_right,
  input  logic [RAW_W-1:0]       distance_left,
  input  logic [RAW_W-1:0]       distance_right,
  input  logic [TIME_W-1:0]      now_ms,
  // result word
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   report_valid,
  output logic [1:0]             urgency,
  output logic [SAMPLE_W-1:0]    avg_front_left,
  output logic [SAMPLE_W-1:0]    avg_front_right,
  output logic [SAMPLE_W-1:0]    avg_back_left,
  output logic [SAMPLE_W-1:0]    avg_back_right,
  output logic [SAMPLE_W-1:0]    avg_left,
  output logic [SAMPLE_W-1:0]    avg_right,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic                            accept;
  logic [CHANNELS-1:0][RAW_W-1:0]  distance;
  logic [CHANNELS-1:0][SUM_W-1:0]  sums;
  sart_flags_t [CHANNELS-1:0]      lane_flags;
  sart_limits_t                    limits;
  sart_intervals_t                 intervals;
  logic [POS_W-1:0]                pos;
  logic [POS_W-1:0]                pos_next;
  logic                            filled;
  logic                            fire;
  sart_result_t                    result;
  sart_result_t                    out_data;

  assign accept = in_valid && in_ready;

  assign distance = {distance_right, distance_left, distance_back_right,
                     distance_back_left, distance_front_right, distance_front_left};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.high_near   <= RST_HIGH_NEAR;
      limits.medium_near <= RST_MEDIUM_NEAR;
      limits.high_jump   <= RST_HIGH_JUMP;
      limits.medium_jump <= RST_MEDIUM_JUMP;
      intervals.high     <= RST_HIGH_INTERVAL;
      intervals.mid      <= RST_MEDIUM_INTERVAL;
      intervals.max      <= RST_MAX_INTERVAL;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HIGH_NEAR:       limits.high_near   <= scale_limit(cfg_data[LIMIT_W-1:0]);
        REG_MEDIUM_NEAR:     limits.medium_near <= scale_limit(cfg_data[LIMIT_W-1:0]);
        REG_HIGH_JUMP:       limits.high_jump   <= scale_limit(cfg_data[LIMIT_W-1:0]);
        REG_MEDIUM_JUMP:     limits.medium_jump <= scale_limit(cfg_data[LIMIT_W-1:0]);
        REG_HIGH_INTERVAL:   intervals.high     <= cfg_data[INTERVAL_W-1:0];
        REG_MEDIUM_INTERVAL: intervals.mid      <= cfg_data[INTERVAL_W-1:0];
        REG_MAX_INTERVAL:    intervals.max      <= cfg_data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Window position and first-wrap flag, shared by all lanes
  assign pos_next = (pos == POS_W'(WINDOW_LENGTH - 1)) ? '0 : pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      filled <= 1'b0;
    end else if (accept) begin
      pos <= pos_next;
      if (pos == POS_W'(WINDOW_LENGTH - 1)) begin
        filled <= 1'b1;
      end
    end
  end

  // Lanes
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    sart_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .accept   (accept),
      .distance (distance[g]),
      .pos      (pos),
      .pos_next (pos_next),
      .filled   (filled),
      .limits   (limits),
      .fire     (fire),
      .sum_new  (sums[g]),
      .flags    (lane_flags[g])
    );
  end

  // Merge
  sart_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sums       (sums),
    .lane_flags (lane_flags),
    .now_ms     (now_ms),
    .intervals  (intervals),
    .fire       (fire),
    .result     (result)
  );

  // Output buffer
  sart_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_ready (in_ready),
    .push_data  (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign report_valid    = out_data.report_valid;
  assign urgency         = out_data.urgency;
  assign avg_front_left  = out_data.avg[0];
  assign avg_front_right = out_data.avg[1];
  assign avg_back_left   = out_data.avg[2];
  assign avg_back_right  = out_data.avg[3];
  assign avg_left        = out_data.avg[4];
  assign avg_right       = out_data.avg[5];

endmodule

### src/sart_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sonar average and report trigger block, bound
// to the top level. Depends on sart_pkg.
module sart_checker import sart_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   report_valid,
  input logic [1:0]             urgency,
  input logic [SAMPLE_W-1:0]    avg_front_left,
  input logic [SAMPLE_W-1:0]    avg_front_right,
  input logic [SAMPLE_W-1:0]    avg_back_left,
  input logic [SAMPLE_W-1:0]    avg_back_right,
  input logic [SAMPLE_W-1:0]    avg_left,
  input logic [SAMPLE_W-1:0]    avg_right
);

  // A word without a report carries zero averages
  a_quiet_avgs: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !report_valid) |->
      (avg_front_left == '0) && (avg_front_right == '0) && (avg_back_left == '0) &&
      (avg_back_right == '0) && (avg_left == '0) && (avg_right == '0))
    else $error("averages non-zero on a word without a report");

  // Nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

  // With the output empty the buffer cannot be full
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // A stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      out_valid && $stable(report_valid) && $stable(urgency) && $stable(avg_front_left))
    else $error("result word changed while stalled");

endmodule

bind sonar_average_report_trigger_unit sart_checker u_sart_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .report_valid    (report_valid),
  .urgency         (urgency),
  .avg_front_left  (avg_front_left),
  .avg_front_right (avg_front_right),
  .avg_back_left   (avg_back_left),
  .avg_back_right  (avg_back_right),
  .avg_left        (avg_left),
  .avg_right       (avg_right)
);

### bench/sonar_average_report_trigger_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sonar_average_report_trigger_unit: a cycle-free
// tracker predicts each result word, which is checked in arrival order.
// Depends on sart_pkg and the RTL of the block.
module sonar_average_report_trigger_unit_test;
  import sart_pkg::*;

  localparam int NUM_REGS = 7;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [CHANNELS-1:0][RAW_W-1:0] range_cm;
    logic [TIME_W-1:0]              stamp;
  } reading_t;

  typedef struct packed {
    logic                              fire;
    logic [1:0]                        urg;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] avg;
  } report_t;

  typedef logic [CFG_DATA_W-1:0] reg_set_t [NUM_REGS];

  localparam reg_set_t REG_DEFAULTS = '{30, 50, 20, 10, 10, 40, 200};
  localparam reg_set_t REG_MASKS = '{16'h00ff, 16'h00ff, 16'h00ff, 16'h00ff,
                                     16'hffff, 16'hffff, 16'hffff};

  // Block inputs, all known from time zero
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic [RAW_W-1:0]       distance_front_left = '0;
  logic [RAW_W-1:0]       distance_front_right = '0;
  logic [RAW_W-1:0]       distance_back_left = '0;
  logic [RAW_W-1:0]       distance_back_right = '0;
  logic [RAW_W-1:0]       distance_left = '0;
  logic [RAW_W-1:0]       distance_right = '0;
  logic [TIME_W-1:0]      now_ms = '0;
  logic                   out_ready = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Block outputs
  logic                in_ready;
  logic                out_valid;
  logic                report_valid;
  logic [1:0]          urgency;
  logic [SAMPLE_W-1:0] avg_front_left;
  logic [SAMPLE_W-1:0] avg_front_right;
  logic [SAMPLE_W-1:0] avg_back_left;
  logic [SAMPLE_W-1:0] avg_back_right;
  logic [SAMPLE_W-1:0] avg_left;
  logic [SAMPLE_W-1:0] avg_right;

  sonar_average_report_trigger_unit u_top (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .distance_front_left  (distance_front_left),
    .distance_front_right (distance_front_right),
    .distance_back_left   (distance_back_left),
    .distance_back_right  (distance_back_right),
    .distance_left        (distance_left),
    .distance_right       (distance_right),
    .now_ms               (now_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .report_valid         (report_valid),
    .urgency              (urgency),
    .avg_front_left       (avg_front_left),
    .avg_front_right      (avg_front_right),
    .avg_back_left        (avg_back_left),
    .avg_back_right       (avg_back_right),
    .avg_left             (avg_left),
    .avg_right            (avg_right),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Tracker state: windows, last report and a shadow of the registers
  int unsigned win_samples [CHANNELS][WINDOW_LENGTH];
  int unsigned win_sums [CHANNELS];
  int unsigned win_pos;
  int unsigned sent_sums [CHANNELS];
  logic [TIME_W-1:0] last_sent_ms;
  int unsigned reg_shadow [NUM_REGS];

  report_t pending_reports [$];

  // Run statistics and fault counters
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned fired_count = 0;
  int unsigned high_count = 0;
  int unsigned medium_count = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  // Handshake pacing
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_off = 1'b0;

  // Scene generator state
  int          chan_base [CHANNELS];
  logic [TIME_W-1:0] clock_ms = '0;

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_reports.size());
      $display("sonar_average_report_trigger_unit: mismatch");
      $finish;
    end
  end

  // Output side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    report_t seen;
    report_t want;
    if (!rst && out_valid && out_ready) begin
      seen.fire = report_valid;
      seen.urg  = urgency;
      seen.avg  = {avg_right, avg_left, avg_back_right, avg_back_left,
                   avg_front_right, avg_front_left};
      if (pending_reports.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result word: report %0d urgency %0d avg %h",
                   seen.fire, seen.urg, seen.avg);
      end else begin
        want = pending_reports.pop_front();
        words_checked++;
        if (seen !== want) begin
          fault_count++;
          if (fault_count <= 10)
            $display("word %0d: report %0d/%0d urgency %0d/%0d avg %h/%h (exp/act)",
                     words_checked, want.fire, seen.fire, want.urg, seen.urg,
                     want.avg, seen.avg);
        end
      end
    end
  end

  // Tracker: back to the post-reset state
  function automatic void reset_tracker();
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < WINDOW_LENGTH; k++) win_samples[c][k] = PREFILL;
      win_sums[c]  = PREFILL * WINDOW_LENGTH;
      sent_sums[c] = 0;
    end
    win_pos = 0;
    last_sent_ms = '0;
    for (int r = 0; r < NUM_REGS; r++) reg_shadow[r] = REG_DEFAULTS[r];
  endfunction

  // Tracker: one accepted word in, the expected result out
  function automatic report_t track_reading(input reading_t rd);
    report_t res;
    int unsigned smp;
    int unsigned sum;
    int unsigned diff;
    logic hi;
    logic med;
    logic [TIME_W-1:0] elapsed;
    int unsigned w;
    w   = WINDOW_LENGTH;
    hi  = 1'b0;
    med = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      smp = (rd.range_cm[c] > SAMPLE_MAX) ? SAMPLE_MAX : rd.range_cm[c];
      win_sums[c] = win_sums[c] + smp - win_samples[c][win_pos];
      win_samples[c][win_pos] = smp;
      sum  = win_sums[c];
      diff = (sent_sums[c] > sum) ? sent_sums[c] - sum : sum - sent_sums[c];
      // a channel graded high is not also counted as medium
      if ((sum < reg_shadow[REG_HIGH_NEAR] * w && diff > 2 * w) ||
          diff > reg_shadow[REG_HIGH_JUMP] * w)
        hi = 1'b1;
      else if ((sum < reg_shadow[REG_MEDIUM_NEAR] * w && diff > 4 * w) ||
               diff > reg_shadow[REG_MEDIUM_JUMP] * w)
        med = 1'b1;
    end
    win_pos = (win_pos + 1) % w;

    // elapsed time wraps modulo 2^32
    elapsed  = rd.stamp - last_sent_ms;
    res.fire = (hi && elapsed > reg_shadow[REG_HIGH_INTERVAL]) ||
               (med && elapsed > reg_shadow[REG_MEDIUM_INTERVAL]) ||
               (elapsed > reg_shadow[REG_MAX_INTERVAL]);
    res.urg  = hi ? URG_HIGH : (med ? URG_MEDIUM : URG_NONE);
    for (int c = 0; c < CHANNELS; c++)
      res.avg[c] = res.fire ? SAMPLE_W'(win_sums[c] / w) : '0;
    if (res.fire) begin
      for (int c = 0; c < CHANNELS; c++) sent_sums[c] = win_sums[c];
      last_sent_ms = rd.stamp;
    end
    return res;
  endfunction

  // Offer one word, hold it until accepted, then log the expected result
  task automatic send_reading(input reading_t rd);
    int unsigned gap;
    report_t res;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    distance_front_left  <= rd.range_cm[0];
    distance_front_right <= rd.range_cm[1];
    distance_back_left   <= rd.range_cm[2];
    distance_back_right  <= rd.range_cm[3];
    distance_left        <= rd.range_cm[4];
    distance_right       <= rd.range_cm[5];
    now_ms               <= rd.stamp;
    do @(posedge clk); while (!in_ready);
    res = track_reading(rd);
    pending_reports.push_back(res);
    words_sent++;
    if (res.fire) fired_count++;
    if (res.urg == URG_HIGH) high_count++;
    else if (res.urg == URG_MEDIUM) medium_count++;
  endtask

  // Drop valid and wait until every result word has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write; the caller lowers the enable after its batch
  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx < NUM_REGS) reg_shadow[idx] = val & REG_MASKS[idx];
  endtask

  task automatic apply_settings(input reg_set_t vals);
    for (int r = 0; r < NUM_REGS; r++) put_reg(CFG_INDEX_W'(r), vals[r]);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic reading_t flat_reading(input logic [RAW_W-1:0] d,
                                            input logic [TIME_W-1:0] t);
    reading_t rd;
    for (int c = 0; c < CHANNELS; c++) rd.range_cm[c] = d;
    rd.stamp = t;
    return rd;
  endfunction

  // Drifting obstacles with occasional jumps, raw noise and time leaps
  function automatic reading_t scene_reading();
    reading_t rd;
    int unsigned roll;
    for (int c = 0; c < CHANNELS; c++) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        chan_base[c] = chan_base[c] + int'($urandom_range(0, 8)) - 4;
        if (chan_base[c] < 0) chan_base[c] = 0;
        if (chan_base[c] > 300) chan_base[c] = 300;
        rd.range_cm[c] = RAW_W'(chan_base[c]);
      end else if (roll < 92) begin
        chan_base[c] = $urandom_range(0, 300);
        rd.range_cm[c] = RAW_W'(chan_base[c]);
      end else if (roll < 97) begin
        rd.range_cm[c] = RAW_W'($urandom_range(0, 65535));
      end else begin
        rd.range_cm[c] = roll[0] ? '1 : '0;
      end
    end
    roll = $urandom_range(0, 99);
    if (roll < 88) clock_ms = clock_ms + $urandom_range(0, 30);
    else if (roll < 96) clock_ms = clock_ms + $urandom_range(31, 70000);
    else clock_ms = $urandom;
    rd.stamp = clock_ms;
    return rd;
  endfunction

  function automatic reg_set_t random_settings();
    reg_set_t vals;
    for (int r = 0; r < NUM_REGS; r++)
      vals[r] = (r <= REG_MEDIUM_JUMP) ? CFG_DATA_W'($urandom_range(0, 80))
                                       : CFG_DATA_W'($urandom_range(0, 300));
    return vals;
  endfunction

  task automatic run_scenes(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_reading(scene_reading());
  endtask

  // Reset state: prefilled windows grade high at once, report after 10 ms
  task automatic test_after_reset();
    send_reading(flat_reading(16'd100, 32'd0));
    send_reading(flat_reading(16'd100, 32'd10));
    send_reading(flat_reading(16'd100, 32'd11));
    send_reading(flat_reading(16'd100, 32'd12));
    settle();
  endtask

  // Saturation edges, all-ones and all-zero fields, time wrap
  task automatic test_field_extremes();
    reading_t rd;
    send_reading(flat_reading(16'd0, 32'd20));
    send_reading(flat_reading(16'hffff, 32'h7fff_ffff));
    send_reading(flat_reading(16'd255, 32'hffff_ffff));
    send_reading(flat_reading(16'd256, 32'd5));
    rd = flat_reading(16'h8000, 32'haaaa_aaaa);
    rd.range_cm[1] = 16'h7fff;
    rd.range_cm[3] = 16'd254;
    rd.range_cm[5] = 16'd0;
    send_reading(rd);
    send_reading(flat_reading(16'd1, 32'h5555_5555));
    send_reading(flat_reading(16'd40, 32'h5555_5560));
    settle();
  endtask

  // Unused index, bits above the register width, and both value extremes
  task automatic test_register_handling();
    put_reg(REG_UNUSED, 16'hffff);
    put_reg(REG_HIGH_NEAR, 16'hff05);
    put_reg(REG_MEDIUM_NEAR, 16'h0100);
    put_reg(REG_HIGH_JUMP, 16'h8003);
    put_reg(REG_MEDIUM_JUMP, 16'h7f00);
    apply_settings('{16'hff05, 16'h0100, 16'h8003, 16'h7f00, 0, 0, 0});
    send_reading(flat_reading(16'd3, 32'h5555_5560));
    send_reading(flat_reading(16'd60, 32'h5555_5561));
    send_reading(flat_reading(16'd61, 32'h5555_5562));
    settle();
    apply_settings('{16'hffff, 16'hffff, 16'hffff, 16'hffff,
                     16'hffff, 16'hffff, 16'hffff});
    send_reading(flat_reading(16'd200, 32'h5555_5562 + 32'd65535));
    send_reading(flat_reading(16'd10, 32'h5555_5562 + 32'd65536));
    send_reading(flat_reading(16'd255, 32'h5555_5562 + 32'd65536 + 32'd65535));
    send_reading(flat_reading(16'd0, 32'h5555_5562 + 32'd65536 + 32'd65536));
    settle();
  endtask

  // Output held off for a long stretch while words keep coming
  task automatic test_output_backpressure();
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    run_scenes(30);
    settle();
  endtask

  task automatic test_default_scenes();
    apply_settings(REG_DEFAULTS);
    send_idle_pct = 20;
    recv_idle_pct = 67;
    run_scenes(280);
    settle();
  endtask

  // Mid-range settings, with the clock walking over the 32-bit wrap
  task automatic test_tuned_scenes();
    apply_settings(random_settings());
    send_idle_pct = 67;
    recv_idle_pct = 20;
    clock_ms = 32'hffff_fe00;
    run_scenes(280);
    settle();
  endtask

  task automatic test_extreme_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings('{0, 0, 0, 0, 0, 0, 0});
    run_scenes(100);
    settle();
    apply_settings('{255, 255, 255, 255, 16'hffff, 16'hffff, 16'hffff});
    run_scenes(100);
    settle();
    apply_settings(random_settings());
    run_scenes(90);
    settle();
  endtask

  initial begin
    reset_tracker();
    for (int c = 0; c < CHANNELS; c++) chan_base[c] = PREFILL;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_after_reset();
    test_field_extremes();
    test_register_handling();
    test_default_scenes();
    test_tuned_scenes();
    test_output_backpressure();
    test_extreme_settings();

    repeat (5) @(posedge clk);
    fault_count = fault_count + pending_reports.size();
    $display("%0d words sent, %0d results checked, %0d faults", words_sent,
             words_checked, fault_count);
    $display("%0d reports fired; urgency high %0d, medium %0d, over default, %s",
             fired_count, high_count, medium_count, "tuned and extreme settings");
    if (fault_count == 0) begin
      $display("sonar_average_report_trigger_unit: match");
    end else begin
      $display("sonar_average_report_trigger_unit: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
src/sart_pkg.sv
src/sart_lane.sv
src/sart_merge.sv
src/sart_outbuf.sv
src/sonar_average_report_trigger_unit.sv
src/sart_checker.sv
bench/sonar_average_report_trigger_unit_test.sv
